/* sv/bsd_pkg.sv */
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared constants and types for the byte-stuffing deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package bsd_pkg;

    // Largest number of decoded bytes kept in one frame (8 .. 4096)
    localparam int MAX_FRAME   = 256;
    // Byte counter must hold MAX_FRAME itself
    localparam int BCNT_W      = $clog2(MAX_FRAME + 1);
    // Counter extended so an 8-bit slice and a saturation test are always legal
    localparam int BCNT_EXT_W  = BCNT_W + 8;

    localparam int ADDR_BYTES  = 6;
    localparam logic [7:0] TOGGLE_MASK = 8'h20;

    // Reset values of the code registers
    localparam logic [7:0] START_CODE_RST  = 8'd126;
    localparam logic [7:0] ESCAPE_CODE_RST = 8'd125;
    localparam logic [7:0] END_CODE_RST    = 8'd127;

    // Configuration register indexes
    localparam logic [1:0] CFG_START  = 2'd0;
    localparam logic [1:0] CFG_ESCAPE = 2'd1;
    localparam logic [1:0] CFG_END    = 2'd2;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_ADDR        = 3'd0,
        KIND_PAYLOAD     = 3'd1,
        KIND_GOOD_END    = 3'd2,
        KIND_DROPPED_END = 3'd3,
        KIND_ABORT       = 3'd4
    } kind_t;

endpackage

`default_nettype wire

/* sv/byte_stuffing_deframer.sv */
// ----------------------------------------------------------------------------
// byte_stuffing_deframer
// Decodes an escaped, byte-stuffed serial stream into address bytes,
// payload bytes and frame end / abort markers, one line byte per cycle unless m_axis stalls.
// ----------------------------------------------------------------------------
//
//  Channel    Dir  Payload                                      Transaction
//  s_axis     in   tdata[7:0] rx_byte                           tvalid & tready
//  m_axis     out  tdata: out_byte, position, payload_length,   tvalid & tready
//                  truncated; tuser: kind
//  cfg        in   cfg_addr (register index), cfg_wr_data       cfg_wr_en
//
//  One byte is taken per cycle while m_axis is not stalled; a byte is held in
//  the input register and its result is written to the output register when
//  the decode step runs. Throughput is set by the single decode step, which
//  reads and updates the frame state in the same cycle. rst_n clears the frame
//  state, both valid flags and restores the default codes. A stalled m_axis
//  holds the result; the input register then fills and s_axis_tready drops.
//
`default_nettype none

module byte_stuffing_deframer
    import bsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [31:0] m_axis_tdata,   // [7:0] out_byte, [15:8] position,
                                             // [23:16] payload_length,
                                             // [24] truncated, [31:25] zero
    output      logic [2:0]  m_axis_tuser,   // [2:0] kind

    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wr_data
);

    // Code registers
    logic [7:0] start_code_reg;
    logic [7:0] escape_code_reg;
    logic [7:0] end_code_reg;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Frame state
    logic              inside_reg,   inside_next;
    logic              esc_reg,      esc_next;
    logic [BCNT_W-1:0] cnt_reg,      cnt_next;
    logic              ovf_reg,      ovf_next;

    // Output register
    logic       out_valid_reg;
    kind_t      kind_reg,     kind_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic [7:0] pos_reg,      pos_next;
    logic [7:0] len_reg,      len_next;
    logic       trunc_reg,    trunc_next;
    logic       res_next;

    logic                  advance;
    logic [7:0]            data_byte;
    logic [BCNT_EXT_W-1:0] cnt_ext;
    logic [BCNT_EXT_W-1:0] pay_ext;

    // Handshake: the decode step runs when an input byte is held and the output slot is free or drained
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tdata  = {7'd0, trunc_reg, len_reg, pos_reg, out_byte_reg};

    // Counter views for position and payload length
    assign cnt_ext   = {8'd0, cnt_reg};
    assign pay_ext   = cnt_ext - BCNT_EXT_W'(ADDR_BYTES);
    assign data_byte = esc_reg ? (in_byte_reg ^ TOGGLE_MASK) : in_byte_reg;

    // Decode step
    always_comb
    begin
        inside_next   = inside_reg;
        esc_next      = esc_reg;
        cnt_next      = cnt_reg;
        ovf_next      = ovf_reg;
        res_next      = 1'b0;
        kind_next     = KIND_ADDR;
        out_byte_next = 8'd0;
        pos_next      = 8'd0;
        len_next      = 8'd0;
        trunc_next    = 1'b0;

        if (in_byte_reg == start_code_reg)
        begin
            // Start code: abort an open frame, then open a fresh one
            if (inside_reg)
            begin
                res_next   = 1'b1;
                kind_next  = KIND_ABORT;
                trunc_next = ovf_reg;
            end
            inside_next = 1'b1;
            esc_next    = 1'b0;
            cnt_next    = '0;
            ovf_next    = 1'b0;
        end
        else if (!inside_reg)
        begin
            // Idle line: byte ignored
        end
        else if (in_byte_reg == end_code_reg)
        begin
            res_next   = 1'b1;
            trunc_next = ovf_reg;
            if (cnt_ext >= BCNT_EXT_W'(ADDR_BYTES))
            begin
                kind_next = KIND_GOOD_END;
                len_next  = (pay_ext > BCNT_EXT_W'(255)) ? 8'hFF : pay_ext[7:0];
            end
            else
            begin
                kind_next = KIND_DROPPED_END;
            end
            inside_next = 1'b0;
            esc_next    = 1'b0;
        end
        else if (in_byte_reg == escape_code_reg)
        begin
            esc_next = 1'b1;
        end
        else
        begin
            esc_next = 1'b0;
            if (cnt_reg == BCNT_W'(MAX_FRAME))
            begin
                // Frame full: drop the byte
                ovf_next = 1'b1;
            end
            else
            begin
                res_next      = 1'b1;
                out_byte_next = data_byte;
                if (cnt_ext < BCNT_EXT_W'(ADDR_BYTES))
                begin
                    kind_next = KIND_ADDR;
                    pos_next  = cnt_ext[7:0];
                end
                else
                begin
                    kind_next = KIND_PAYLOAD;
                    pos_next  = pay_ext[7:0];
                end
                cnt_next = cnt_reg + BCNT_W'(1);
            end
        end
    end

    // Code registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg  <= START_CODE_RST;
            escape_code_reg <= ESCAPE_CODE_RST;
            end_code_reg    <= END_CODE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_START:  start_code_reg  <= cfg_wr_data;
                CFG_ESCAPE: escape_code_reg <= cfg_wr_data;
                CFG_END:    end_code_reg    <= cfg_wr_data;
                default:    ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // Frame state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg    <= 1'b0;
            esc_reg       <= 1'b0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                inside_reg    <= inside_next;
                esc_reg       <= esc_next;
                cnt_reg       <= cnt_next;
                ovf_reg       <= ovf_next;
                out_valid_reg <= res_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance && res_next)
        begin
            kind_reg     <= kind_next;
            out_byte_reg <= out_byte_next;
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            trunc_reg    <= trunc_next;
        end
    end

endmodule

`default_nettype wire
